// ----- hw/rtl/bresenham_line_rasterizer_core_macros.svh -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core_macros
// assertion shorthands used by the checker file of the line engine
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define BLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line engine check failed");

// next-cycle implication, quiet while reset is held
`define BLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line engine check failed");

// what must hold on the cycle after reset is seen
`define BLR_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("line engine reset check failed");

`endif

// ----- hw/rtl/blr_pkg.sv -----
// ----------------------------------------------------------------------------
// blr_pkg
// shared widths, field offsets, codes and control structs of the line engine
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ROW_SHIFT  = 10;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 32;
    localparam int DIM_W      = 11;
    localparam int ERR_W      = COORD_BITS + 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
    localparam logic [ADDR_W-1:0]    RST_FRAME_BASE    = '0;
    localparam logic [DIM_W-1:0]     RST_SCREEN_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0]     RST_SCREEN_HEIGHT = 11'd240;

    // command codes carried in tuser
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // input beat layout
    localparam int OFF_SX    = 0;
    localparam int OFF_SY    = OFF_SX + COORD_BITS;
    localparam int OFF_EX    = OFF_SY + COORD_BITS;
    localparam int OFF_EY    = OFF_EX + COORD_BITS;
    localparam int OFF_COLOR = OFF_EY + COORD_BITS;
    localparam int S_BITS    = OFF_COLOR + COLOR_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int OFF_PX    = 0;
    localparam int OFF_PY    = OFF_PX + COORD_BITS;
    localparam int OFF_PCOL  = OFF_PY + COORD_BITS;
    localparam int OFF_ADDR  = OFF_PCOL + COLOR_W;
    localparam int M_BITS    = OFF_ADDR + ADDR_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_delta;
    typedef logic [ERR_W-1:0]      t_err;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef struct packed {
        logic load;   // start beat taken: latch endpoints
        logic setup;  // order endpoints, derive deltas and error
        logic emit;   // advance beat taken on an active line
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic last;
    } t_dp_sts;

endpackage

// ----- hw/rtl/bresenham_line_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Bresenham line engine with clipping and frame-buffer address generation
// ----------------------------------------------------------------------------
// Input stream: tuser is the command. A start beat (tuser 0) carries both
// endpoints and the colour; it yields no pixel and replaces any line in
// progress. It is followed by a setup state in which tready is low. An
// advance beat (tuser 1) on an active line yields one pixel in the cycle
// after it is taken; an advance with no line active is taken and dropped.
// Advances run at one beat per cycle while the receiver takes pixels, set by
// the error update and the one-deep output register.
// Output stream: tdata holds x, y, colour and byte address, tuser the visible
// flag, tlast marks the final pixel of the line (major delta plus one pixels).
// When the receiver stalls, the pixel is held in the output register and
// input tready drops until the pixel is taken.
// Reset: frame base 0, screen 320 by 240, no line active, output empty.
// Configuration writes take effect on the next cycle; write them while idle.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core import blr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_x, pixel_y, pixel_color, pixel_address
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // visible
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    blr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .i_sts      (dp_sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    blr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/blr_ctrl.sv -----
// ----------------------------------------------------------------------------
// blr_ctrl
// line engine sequencer: idle, a setup state per start, then drawing
// ----------------------------------------------------------------------------
module blr_ctrl import blr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_DRAW  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // output register free or draining this cycle
    assign o_s_tready = (r_state != S_SETUP) && (!i_sts.out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_cmd.load  = accept && (i_s_tuser == CMD_START);
    assign o_cmd.emit  = accept && (i_s_tuser == CMD_ADVANCE) && (r_state == S_DRAW);
    assign o_cmd.setup = (r_state == S_SETUP);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (o_cmd.load) begin
                    n_state = S_SETUP;
                end else if (o_cmd.emit && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/blr_datapath.sv -----
// ----------------------------------------------------------------------------
// blr_datapath
// endpoint ordering, error stepping, clipping, address and output register
// ----------------------------------------------------------------------------
module blr_datapath import blr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

    function automatic t_delta sub_ext(t_coord a, t_coord b);
        return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    function automatic t_delta abs_delta(t_delta d);
        return d[COORD_BITS] ? (~d + 1'b1) : d;
    endfunction

    function automatic t_addr sext_addr(t_coord c);
        return {{(ADDR_W-COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;

    // latched endpoints
    t_coord               r_x0, r_y0, r_x1, r_y1;
    logic                 r_steep;
    logic [COLOR_W-1:0]   r_color;

    // line state
    t_coord r_major, r_major_end, r_minor;
    logic   r_neg;
    t_delta r_majd, r_mind;
    t_err   r_err;

    // output register
    logic               r_out_valid;
    t_coord             r_out_x, r_out_y;
    logic [COLOR_W-1:0] r_out_color;
    t_addr              r_out_addr;
    logic               r_out_vis, r_out_last;

    t_coord in_x0, in_y0, in_x1, in_y1;
    t_delta adx, ady;
    t_coord a0, b0, a1, b1;
    t_delta da, db, majd0, mind0;
    logic   swap, rise;
    t_err   half, err0;
    t_err   e1, e2;
    logic   e1_pos;
    t_coord px, py, major_nx, minor_nx;
    logic   last, vis;
    t_addr  addr;

    assign in_x0 = i_s_tdata[OFF_SX +: COORD_BITS];
    assign in_y0 = i_s_tdata[OFF_SY +: COORD_BITS];
    assign in_x1 = i_s_tdata[OFF_EX +: COORD_BITS];
    assign in_y1 = i_s_tdata[OFF_EY +: COORD_BITS];
    assign adx   = abs_delta(sub_ext(in_x1, in_x0));
    assign ady   = abs_delta(sub_ext(in_y1, in_y0));

    // setup: swap axes for steep lines, order by major coordinate
    assign a0    = r_steep ? r_y0 : r_x0;
    assign b0    = r_steep ? r_x0 : r_y0;
    assign a1    = r_steep ? r_y1 : r_x1;
    assign b1    = r_steep ? r_x1 : r_y1;
    assign da    = sub_ext(a1, a0);
    assign db    = sub_ext(b1, b0);
    assign swap  = da[COORD_BITS];
    assign majd0 = abs_delta(da);
    assign mind0 = abs_delta(db);
    assign rise  = swap ? db[COORD_BITS] : (!db[COORD_BITS] && (|db));
    assign half  = {2'b00, majd0[COORD_BITS:1]};
    assign err0  = ~half + 1'b1;

    // stepping: add minor delta, step minor and pull back on a positive error
    assign e1       = r_err + {1'b0, r_mind};
    assign e2       = e1 - {1'b0, r_majd};
    assign e1_pos   = !e1[ERR_W-1] && (|e1);
    assign major_nx = r_major + t_coord'(1);
    assign minor_nx = r_minor + (r_neg ? {COORD_BITS{1'b1}} : t_coord'(1));
    assign last     = (r_major == r_major_end);

    assign px   = r_steep ? r_minor : r_major;
    assign py   = r_steep ? r_major : r_minor;
    assign addr = r_base + (sext_addr(py) << ROW_SHIFT) + (sext_addr(px) << 1);
    assign vis  = !px[COORD_BITS-1] && !py[COORD_BITS-1]
                  && (CMP_W'(px) < CMP_W'(r_width))
                  && (CMP_W'(py) < CMP_W'(r_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= RST_FRAME_BASE;
            r_width  <= RST_SCREEN_WIDTH;
            r_height <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_BASE:    r_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0    <= in_x0;
            r_y0    <= in_y0;
            r_x1    <= in_x1;
            r_y1    <= in_y1;
            r_steep <= (ady > adx);
            r_color <= i_s_tdata[OFF_COLOR +: COLOR_W];
        end
        if (i_cmd.setup) begin
            r_major     <= swap ? a1 : a0;
            r_major_end <= swap ? a0 : a1;
            r_minor     <= swap ? b1 : b0;
            r_neg       <= !rise;
            r_majd      <= majd0;
            r_mind      <= mind0;
            r_err       <= err0;
        end else if (i_cmd.emit && !last) begin
            r_major <= major_nx;
            r_err   <= e1_pos ? e2 : e1;
            if (e1_pos) r_minor <= minor_nx;
        end
        if (i_cmd.emit) begin
            r_out_x     <= px;
            r_out_y     <= py;
            r_out_color <= r_color;
            r_out_addr  <= addr;
            r_out_vis   <= vis;
            r_out_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_sts.last      = last;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_addr, r_out_color, r_out_y, r_out_x});
    assign o_m_tuser  = r_out_vis;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- hw/rtl/blr_checker.sv -----
// ----------------------------------------------------------------------------
// blr_checker
// port-level checks of the line engine, bound to the top level
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_checker import blr_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 i_s_tready,
    input logic                 i_s_tuser,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata,
    input logic                 i_m_tuser
);

    // output stays up until taken
    `BLR_ASSERT_NXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid)
    // a stalled output blocks the input side
    `BLR_ASSERT_IMP(a_stall_blocks_in, i_m_tvalid && !i_m_tready, !i_s_tready)
    // a visible pixel never has a negative coordinate
    `BLR_ASSERT_IMP(a_vis_nonneg, i_m_tvalid && i_m_tuser, !i_m_tdata[OFF_PX + COORD_BITS - 1] && !i_m_tdata[OFF_PY + COORD_BITS - 1])
    // a new pixel only follows an accepted advance beat
    `BLR_ASSERT_IMP(a_pixel_from_adv, $rose(i_m_tvalid), $past(i_s_tvalid && i_s_tready && (i_s_tuser == CMD_ADVANCE)))
    // output empty out of reset
    `BLR_ASSERT_RST(a_rst_empty, !i_m_tvalid)

endmodule

bind bresenham_line_rasterizer_core blr_checker u_blr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ----- tb/tb_bresenham_line_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer_core
// Self-checking bench for the line engine. A short table of directed beats
// (idle advances, single points, screen corners, coordinate extremes, steep,
// falling and vertical lines, a restart mid-line) is followed by random lines
// under several frame and screen settings, with bursty input and a stalling
// receiver. Pixels are checked against the bench's line tracer or typed values.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer_core;
    import blr_pkg::*;

    localparam int NUM_DIR     = 25;
    localparam int PHASE_ITEMS = 180;
    localparam int SETTLE      = 8;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        t_coord               x;
        t_coord               y;
        logic [COLOR_W-1:0]   color;
        t_addr                addr;
        logic                 vis;
        logic                 last;
    } t_pixel;

    typedef struct packed {
        logic                 cmd;
        t_coord               sx;
        t_coord               sy;
        t_coord               ex;
        t_coord               ey;
        logic [COLOR_W-1:0]   color;
        logic                 typed;
        t_pixel               pix;
    } t_dir_row;

    localparam t_pixel NO_PIX = '0;

    // pixels are typed in only for single-point lines
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_START,   12'h000, 12'h000, 12'h000, 12'h000, 16'hFFFF, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b1,
          '{12'h000, 12'h000, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1}},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_START,   12'd319, 12'd239, 12'd319, 12'd239, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b1,
          '{12'd319, 12'd239, 16'h0000, 32'd245374, 1'b1, 1'b1}},
        '{CMD_START,   12'd320, 12'h000, 12'd320, 12'h000, 16'h1234, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b1,
          '{12'd320, 12'h000, 16'h1234, 32'd640, 1'b0, 1'b1}},
        '{CMD_START,   12'h800, 12'h7FF, 12'h800, 12'h7FF, 16'hAAAA, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b1,
          '{12'h800, 12'h7FF, 16'hAAAA, 32'd2092032, 1'b0, 1'b1}},
        '{CMD_START,   12'h7FF, 12'h800, 12'h7FF, 12'h800, 16'h5555, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b1,
          '{12'h7FF, 12'h800, 16'h5555, 32'hFFE0_0FFE, 1'b0, 1'b1}},
        // steep line, only partly drawn
        '{CMD_START,   12'd0,   12'd0,   12'd2,   12'd5,   16'hF800, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        // restart mid-line with a falling minor axis
        '{CMD_START,   12'd0,   12'd3,   12'd5,   12'd0,   16'h07E0, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX},
        // vertical line drawn upward after ordering
        '{CMD_START,   12'd3,   12'd7,   12'd3,   12'd0,   16'h001F, 1'b0, NO_PIX},
        '{CMD_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, 1'b0, NO_PIX}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_START;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FRAME_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // line tracer state and its copy of the registers
    logic               line_active = 1'b0;
    logic               steep = 1'b0;
    int                 maj_pos = 0;
    int                 maj_end = 0;
    int                 min_pos = 0;
    logic               min_neg = 1'b0;
    int                 maj_d = 0;
    int                 min_d = 0;
    int                 err = 0;
    logic [COLOR_W-1:0] held_color = '0;
    t_addr              frame_base = RST_FRAME_BASE;
    logic [DIM_W-1:0]   scr_w = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0]   scr_h = RST_SCREEN_HEIGHT;

    t_pixel      pix_q [$];
    int          n_bad = 0;
    int          burst_left = 0;
    int          cycle_cnt = 0;
    logic [8:0]  rx_cyc = '0;

    bresenham_line_rasterizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int iabs(input int v);
        return v < 0 ? -v : v;
    endfunction

    // update the tracer for one accepted beat; 1 if the beat did any work
    function automatic bit trace_beat(input logic cmd, input logic [S_TDATA_W-1:0] data,
                                      input logic typed, input t_pixel typed_pix);
        int x0, y0, x1, y1, a0, b0, a1, b1, t, px, py;
        t_pixel p;
        if (cmd == CMD_START) begin
            x0 = $signed(data[OFF_SX +: COORD_BITS]);
            y0 = $signed(data[OFF_SY +: COORD_BITS]);
            x1 = $signed(data[OFF_EX +: COORD_BITS]);
            y1 = $signed(data[OFF_EY +: COORD_BITS]);
            steep = iabs(y1 - y0) > iabs(x1 - x0);
            if (steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            maj_pos     = a0;
            maj_end     = a1;
            min_pos     = b0;
            maj_d       = a1 - a0;
            min_d       = iabs(b1 - b0);
            min_neg     = !(b0 < b1);
            err         = -(maj_d / 2);
            held_color  = data[OFF_COLOR +: COLOR_W];
            line_active = 1'b1;
            return 1'b1;
        end
        if (!line_active)
            return 1'b0;
        px = steep ? min_pos : maj_pos;
        py = steep ? maj_pos : min_pos;
        p.x     = t_coord'(px);
        p.y     = t_coord'(py);
        p.color = held_color;
        p.addr  = frame_base + (t_addr'(py) << ROW_SHIFT) + (t_addr'(px) << 1);
        p.vis   = px >= 0 && py >= 0 && px < int'(scr_w) && py < int'(scr_h);
        p.last  = maj_pos == maj_end;
        if (p.last) begin
            line_active = 1'b0;
        end else begin
            maj_pos++;
            err += min_d;
            if (err > 0) begin
                min_pos += min_neg ? -1 : 1;
                err -= maj_d;
            end
        end
        pix_q.push_back(typed ? typed_pix : p);
        return 1'b1;
    endfunction

    // bursty sender: returns at the edge where the beat is taken
    task automatic send_beat(input logic cmd, input logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold off input until every pixel is out and the engine has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_screen(input t_addr base, input logic [DIM_W-1:0] w,
                               input logic [DIM_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_base = base;
        scr_w      = w;
        scr_h      = h;
        @(posedge i_clk);
    endtask

    // receiver: ready pattern steps through four modes, picked by the top bits of rx_cyc
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1'b1;
        case (rx_cyc[8:7])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= $urandom_range(0, 3) != 0;
            2'd2:    m_axis_tready <= rx_cyc[2:0] != 3'd5;
            default: m_axis_tready <= rx_cyc[4:3] != 2'd0;
        endcase
    end

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x     = m_axis_tdata[OFF_PX +: COORD_BITS];
            got.y     = m_axis_tdata[OFF_PY +: COORD_BITS];
            got.color = m_axis_tdata[OFF_PCOL +: COLOR_W];
            got.addr  = m_axis_tdata[OFF_ADDR +: ADDR_W];
            got.vis   = m_axis_tuser;
            got.last  = m_axis_tlast;
            if (pix_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected pixel x=%0d y=%0d addr=%h", $signed(got.x),
                             $signed(got.y), got.addr);
            end else begin
                want = pix_q.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("expected x=%0d y=%0d color=%h addr=%h vis=%b last=%b",
                                 $signed(want.x), $signed(want.y), want.color, want.addr,
                                 want.vis, want.last);
                        $display("got      x=%0d y=%0d color=%h addr=%h vis=%b last=%b",
                                 $signed(got.x), $signed(got.y), got.color, got.addr,
                                 got.vis, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("timeout with %0d pixels outstanding", pix_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_dir_row             row;
        logic [S_TDATA_W-1:0] beat;
        int                   ph, phase_items, kind, span, pixels, n_adv;
        int                   x0, y0, x1, y1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIR; i++) begin
            row  = DIR_ROWS[i];
            beat = {row.color, row.ey, row.ex, row.sy, row.sx};
            send_beat(row.cmd, beat);
            void'(trace_beat(row.cmd, beat, row.typed, row.pix));
        end

        for (ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1: load_screen(32'hFFFF_FFFF, 11'd1024, 11'd1024);
                    2: load_screen('0, 11'd1, 11'd1);
                    3: load_screen($urandom, '0, '0);
                    4: load_screen($urandom, 11'($urandom_range(1, 1024)),
                                   11'($urandom_range(1, 1024)));
                    default: load_screen($urandom, 11'd640, 11'd480);
                endcase
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 4) begin
                    // lone advance, usually with no line behind it
                    beat = {$urandom, $urandom};
                    send_beat(CMD_ADVANCE, beat);
                    if (trace_beat(CMD_ADVANCE, beat, 1'b0, NO_PIX))
                        phase_items++;
                end else begin
                    span = int'(scr_w > scr_h ? scr_w : scr_h) + 16;
                    if (kind < 12) begin
                        x0 = int'($urandom_range(0, 4095)) - 2048;
                        y0 = int'($urandom_range(0, 4095)) - 2048;
                        x1 = int'($urandom_range(0, 4095)) - 2048;
                        y1 = int'($urandom_range(0, 4095)) - 2048;
                    end else if (kind < 16) begin
                        x0 = int'($urandom_range(0, span + 40)) - 40;
                        y0 = int'($urandom_range(0, span + 40)) - 40;
                        x1 = x0 + int'($urandom_range(0, 200)) - 100;
                        y1 = y0 + int'($urandom_range(0, 200)) - 100;
                    end else begin
                        x0 = int'($urandom_range(0, span + 16)) - 16;
                        y0 = int'($urandom_range(0, span + 16)) - 16;
                        x1 = x0 + int'($urandom_range(0, 24)) - 12;
                        y1 = y0 + int'($urandom_range(0, 24)) - 12;
                    end
                    pixels = (iabs(x1 - x0) > iabs(y1 - y0) ? iabs(x1 - x0)
                                                             : iabs(y1 - y0)) + 1;
                    // long lines are only started and sampled, never run out
                    if (kind < 12) begin
                        n_adv = $urandom_range(1, 12);
                    end else begin
                        case ($urandom_range(0, 9))
                            0:       n_adv = $urandom_range(0, pixels - 1);
                            1:       n_adv = pixels + $urandom_range(1, 3);
                            default: n_adv = pixels;
                        endcase
                    end
                    beat = {16'($urandom), t_coord'(y1), t_coord'(x1), t_coord'(y0),
                            t_coord'(x0)};
                    send_beat(CMD_START, beat);
                    void'(trace_beat(CMD_START, beat, 1'b0, NO_PIX));
                    phase_items++;
                    repeat (n_adv) begin
                        beat = {$urandom, $urandom};
                        send_beat(CMD_ADVANCE, beat);
                        if (trace_beat(CMD_ADVANCE, beat, 1'b0, NO_PIX))
                            phase_items++;
                    end
                end
            end
        end

        drain();
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
